// File: src/i2cme_pkg.sv
// ----------------------------------------------------------------------------
// i2cme_pkg
// Shared types and codes for the I2C master byte engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cme_pkg;

	localparam int TickWidth = 16;

	// Command opcodes as they arrive on the input item
	localparam logic [2:0] OP_START    = 3'd0;
	localparam logic [2:0] OP_STOP     = 3'd1;
	localparam logic [2:0] OP_WRITE    = 3'd2;
	localparam logic [2:0] OP_READ_ACK = 3'd3;
	localparam logic [2:0] OP_READ_NAK = 3'd4;

	localparam logic [TickWidth-1:0] TICKS_RESET = 16'd4;
	localparam logic [3:0]           BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] opcode;
		logic [7:0] write_byte;
		logic       sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       ready_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       ack_ok;
	} rsp_t;

	// Command class worked out by the front end
	typedef enum logic [2:0] {
		CK_NONE    = 3'd0,
		CK_START   = 3'd1,
		CK_STOP    = 3'd2,
		CK_WRITE   = 3'd3,
		CK_RD_ACK  = 3'd4,
		CK_RD_NAK  = 3'd5
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] wbyte;
		logic       sda;
	} tick_t;

endpackage

// File: src/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Throughput: one item per cycle while the result queue is not full, one result per item.
// Results: the sequencer takes each tick from the tick queue and writes its
// result to the result queue at that same edge; it stalls while the result
// queue is full.
// Reset: queues empty, sequencer idle, SCL/SDA released, ticks_q 4.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_byte_engine #(
	parameter int CMD_DEPTH = 4,
	parameter int RES_DEPTH = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  i2cme_pkg::cmd_t                  cmd,
	output logic                             full,
	input  logic                             pop,
	output i2cme_pkg::rsp_t                  rsp,
	output logic                             empty,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [i2cme_pkg::TickWidth-1:0]  cfg_data
);

	import i2cme_pkg::*;

	tick_t q_item;
	logic  q_empty;
	logic  q_pop;
	rsp_t  res;
	logic  res_push;
	logic  res_full;

	i2cme_front #(
		.DEPTH (CMD_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd     (cmd),
		.full    (full),
		.q_pop   (q_pop),
		.q_item  (q_item),
		.q_empty (q_empty)
	);

	i2cme_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	i2cme_fifo #(
		.DEPTH  (RES_DEPTH),
		.data_t (rsp_t)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (rsp),
		.empty  (empty)
	);

endmodule

// File: src/i2cme_fifo.sv
// ----------------------------------------------------------------------------
// i2cme_fifo
// Small first-in first-out queue with registered storage and occupancy count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cme_fifo #(
	parameter int DEPTH = 2,
	parameter type data_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  data_t wdata,
	output logic  full,
	input  logic  pop,
	output data_t rdata,
	output logic  empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	data_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: src/i2cme_front.sv
// ----------------------------------------------------------------------------
// i2cme_front
// Takes input items, classifies the offered command and queues the tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cme_front #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  i2cme_pkg::cmd_t   cmd,
	output logic              full,
	input  logic              q_pop,
	output i2cme_pkg::tick_t  q_item,
	output logic              q_empty
);

	import i2cme_pkg::*;

	tick_t tick;

	// Out-of-range opcodes and idle offers both become a plain tick
	always_comb begin
		tick.wbyte = cmd.write_byte;
		tick.sda   = cmd.sda_in;
		tick.kind  = CK_NONE;
		if (cmd.cmd_valid) begin
			unique case (cmd.opcode)
				OP_START:    tick.kind = CK_START;
				OP_STOP:     tick.kind = CK_STOP;
				OP_WRITE:    tick.kind = CK_WRITE;
				OP_READ_ACK: tick.kind = CK_RD_ACK;
				OP_READ_NAK: tick.kind = CK_RD_NAK;
				default:     tick.kind = CK_NONE;
			endcase
		end
	end

	i2cme_fifo #(
		.DEPTH  (DEPTH),
		.data_t (tick_t)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (tick),
		.full   (full),
		.pop    (q_pop),
		.rdata  (q_item),
		.empty  (q_empty)
	);

endmodule

// File: src/i2cme_engine.sv
// ----------------------------------------------------------------------------
// i2cme_engine
// Bus sequencer: steps SCL/SDA through each command, one queued tick a cycle while the result queue has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cme_engine (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [i2cme_pkg::TickWidth-1:0]       cfg_data,
	input  logic                                  q_empty,
	input  i2cme_pkg::tick_t                      q_item,
	output logic                                  q_pop,
	input  logic                                  res_full,
	output logic                                  res_push,
	output i2cme_pkg::rsp_t                       res
);

	import i2cme_pkg::*;

	typedef enum logic [13:0] {
		ST_IDLE      = 14'h0001,
		ST_START_A   = 14'h0002,
		ST_START_B   = 14'h0004,
		ST_STOP_A    = 14'h0008,
		ST_STOP_B    = 14'h0010,
		ST_STOP_C    = 14'h0020,
		ST_WR_LOW    = 14'h0040,
		ST_WR_HIGH   = 14'h0080,
		ST_WACK_LOW  = 14'h0100,
		ST_WACK_HIGH = 14'h0200,
		ST_RD_LOW    = 14'h0400,
		ST_RD_HIGH   = 14'h0800,
		ST_RACK_LOW  = 14'h1000,
		ST_RACK_HIGH = 14'h2000
	} state_t;

	state_t                 step_q, n_step;
	logic [TickWidth-1:0]   ticks_q;
	logic [TickWidth-1:0]   wait_q, n_wait;
	logic [TickWidth-1:0]   ilen;
	logic [3:0]             bits_q, n_bits;
	logic [7:0]             shift_q, n_shift;
	logic [7:0]             rx_q, n_rx;
	logic                   scl_q, n_scl;
	logic                   sda_q, n_sda;
	logic                   ack_q, n_ack;
	logic                   nak_q, n_nak;
	logic                   done;
	logic                   fire;

	assign cfg_ready = 1'b1;
	assign fire      = !q_empty && !res_full;
	assign q_pop     = fire;
	assign res_push  = fire;
	assign ilen      = (ticks_q == '0) ? TickWidth'(1) : ticks_q;

	always_comb begin
		n_step  = step_q;
		n_wait  = wait_q;
		n_bits  = bits_q;
		n_shift = shift_q;
		n_rx    = rx_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_ack   = ack_q;
		n_nak   = nak_q;
		done    = 1'b0;
		if (step_q == ST_IDLE) begin
			unique case (q_item.kind)
				CK_START: begin
					n_sda  = 1'b1;
					n_scl  = 1'b1;
					n_step = ST_START_A;
					n_wait = ilen;
				end
				CK_STOP: begin
					n_scl  = 1'b0;
					n_sda  = 1'b0;
					n_step = ST_STOP_A;
					n_wait = ilen;
				end
				CK_WRITE: begin
					n_shift = q_item.wbyte;
					n_bits  = BITS_PER_BYTE;
					n_scl   = 1'b0;
					n_sda   = q_item.wbyte[7];
					n_step  = ST_WR_LOW;
					n_wait  = ilen;
				end
				CK_RD_ACK, CK_RD_NAK: begin
					n_nak   = (q_item.kind == CK_RD_NAK);
					n_shift = '0;
					n_bits  = BITS_PER_BYTE;
					n_scl   = 1'b0;
					n_sda   = 1'b1;
					n_step  = ST_RD_LOW;
					n_wait  = ilen;
				end
				default: begin
					n_step = ST_IDLE;
				end
			endcase
		end else if (wait_q > TickWidth'(1)) begin
			n_wait = wait_q - 1'b1;
		end else begin
			unique case (step_q)
				ST_START_A: begin
					n_sda  = 1'b0;
					n_step = ST_START_B;
					n_wait = ilen;
				end
				ST_START_B: begin
					n_scl = 1'b0;
					done  = 1'b1;
				end
				ST_STOP_A: begin
					n_scl  = 1'b1;
					n_step = ST_STOP_B;
					n_wait = ilen;
				end
				ST_STOP_B: begin
					n_sda  = 1'b1;
					n_step = ST_STOP_C;
					n_wait = ilen;
				end
				ST_STOP_C: begin
					done = 1'b1;
				end
				ST_WR_LOW, ST_WACK_LOW, ST_RD_LOW, ST_RACK_LOW: begin
					n_scl  = 1'b1;
					n_wait = ilen;
					n_step = (step_q == ST_WR_LOW)   ? ST_WR_HIGH :
					         (step_q == ST_WACK_LOW) ? ST_WACK_HIGH :
					         (step_q == ST_RD_LOW)   ? ST_RD_HIGH : ST_RACK_HIGH;
				end
				ST_WR_HIGH: begin
					n_scl   = 1'b0;
					n_bits  = bits_q - 1'b1;
					n_shift = {shift_q[6:0], 1'b0};
					n_wait  = ilen;
					if (n_bits != '0) begin
						n_sda  = shift_q[6];
						n_step = ST_WR_LOW;
					end else begin
						n_sda  = 1'b1;
						n_step = ST_WACK_LOW;
					end
				end
				ST_WACK_HIGH: begin
					n_ack = !q_item.sda;
					n_scl = 1'b0;
					done  = 1'b1;
				end
				ST_RD_HIGH: begin
					n_shift = {shift_q[6:0], q_item.sda};
					n_scl   = 1'b0;
					n_bits  = bits_q - 1'b1;
					n_wait  = ilen;
					if (n_bits != '0) begin
						n_step = ST_RD_LOW;
					end else begin
						n_sda  = nak_q;
						n_step = ST_RACK_LOW;
					end
				end
				ST_RACK_HIGH: begin
					n_scl = 1'b0;
					n_rx  = shift_q;
					done  = 1'b1;
				end
				default: begin
					done = 1'b0;
				end
			endcase
			if (done) begin
				n_step = ST_IDLE;
				n_wait = '0;
			end
		end
	end

	assign res.scl_out   = n_scl;
	assign res.sda_out   = n_sda;
	assign res.ready_res = (n_step == ST_IDLE);
	assign res.done_res  = done;
	assign res.read_byte = n_rx;
	assign res.ack_ok    = n_ack;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_RESET;
			step_q  <= ST_IDLE;
			wait_q  <= '0;
			bits_q  <= '0;
			shift_q <= '0;
			rx_q    <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			nak_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				ticks_q <= cfg_data;
			end
			if (fire) begin
				step_q  <= n_step;
				wait_q  <= n_wait;
				bits_q  <= n_bits;
				shift_q <= n_shift;
				rx_q    <= n_rx;
				scl_q   <= n_scl;
				sda_q   <= n_sda;
				ack_q   <= n_ack;
				nak_q   <= n_nak;
			end
		end
	end

endmodule

// File: src/i2cme_checker.sv
// ----------------------------------------------------------------------------
// i2cme_checker
// Port-level checks for the I2C master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cme_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            push,
	input logic            full,
	input logic            pop,
	input logic            empty,
	input i2cme_pkg::rsp_t rsp
);

	// A completed command always leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.done_res) |-> rsp.ready_res)
		else $error("done result without ready");

	// Every accepted item must be followed by a waiting result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |-> ##2 !empty)
		else $error("result missing after accepted item");

	// A result that is not taken stays in place
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(rsp)))
		else $error("waiting result changed");

endmodule

bind i2c_master_byte_engine i2cme_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.pop    (pop),
	.empty  (empty),
	.rsp    (rsp)
);
